@@ rtl/bpt_pkg.sv @@
// bpt_pkg: shared types, constants and helpers of the beacon presence table
// used by beacon_presence_table_unit; depends on nothing
package bpt_pkg;

    localparam int TABLE_SLOTS = 32;
    localparam int MAX_RESULTS = 32;
    localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
    localparam int RES_CNT_W = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;
    localparam int SLOT_W = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [7:0] GOOD_LENGTH = 8'd12;

    localparam logic CMD_BEACON = 1'b0;
    localparam logic CMD_REPORT = 1'b1;

    localparam logic [1:0] KIND_BEACON = 2'd0;
    localparam logic [1:0] KIND_ENTRY  = 2'd1;
    localparam logic [1:0] KIND_EMPTY  = 2'd2;

    localparam logic [1:0] ST_UPDATED = 2'd0;
    localparam logic [1:0] ST_NEW     = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_BAD_LEN = 2'd3;

    localparam logic [1:0] CLASS_NEAR = 2'd0;
    localparam logic [1:0] CLASS_MID  = 2'd1;
    localparam logic [1:0] CLASS_FAR  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MID     = 2'd2;

    localparam logic [31:0]       TIMEOUT_RESET = 32'd2500;
    localparam logic signed [7:0] NEAR_RESET    = -8'sd70;
    localparam logic signed [7:0] MID_RESET     = -8'sd85;

    typedef struct packed {
        logic              command;
        logic [31:0]       sender_id;
        logic [31:0]       sequence_req;
        logic signed [7:0] signal_strength;
        logic [7:0]        payload_length;
        logic [31:0]       timestamp_ms;
    } bpt_req_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [1:0]        beacon_status;
        logic [SLOT_W-1:0] slot_index;
        logic [31:0]       entry_id;
        logic              is_present;
        logic [31:0]       age_ms;
        logic [31:0]       last_sequence;
        logic signed [7:0] last_strength;
        logic [1:0]        distance_class;
        logic              any_present;
        logic              last_of_run;
    } bpt_rsp_t;

    typedef struct packed {
        logic [31:0]       sender;
        logic [31:0]       sequence_num;
        logic [31:0]       seen_time;
        logic signed [7:0] strength;
    } bpt_entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_WRITE,
        S_RFIND,
        S_RDATA,
        S_RCALC,
        S_EMIT
    } bpt_state_t;

    function automatic logic [1:0] classify(
        input logic signed [7:0] strength,
        input logic signed [7:0] near_thr,
        input logic signed [7:0] mid_thr
    );
        logic [1:0] cls;
        if (strength >= near_thr)
        begin
            cls = CLASS_NEAR;
        end
        else if (strength >= mid_thr)
        begin
            cls = CLASS_MID;
        end
        else
        begin
            cls = CLASS_FAR;
        end
        return cls;
    endfunction

endpackage

@@ rtl/beacon_presence_table_unit.sv @@
// beacon_presence_table_unit: aging presence table of beacon senders, uses bpt_pkg and bpt_ram
// bad-length beacons and reports on an empty table go straight to their result beat; other
// beacons read the slots in order, all when the id is new or the table is full, else up to
// the hit (one slot read per cycle on the single ram read port); reports skip unused slots,
// take each used one through read, calc and emit, waiting on stalls; one item at a time, the
// next is taken the cycle after the last beat loads; reset: slot flags cleared at once
module beacon_presence_table_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_stall,
    input  bpt_pkg::bpt_req_t              req,
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output bpt_pkg::bpt_rsp_t              rsp,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bpt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bpt_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int ENTRY_W = $bits(bpt_pkg::bpt_entry_t);

    bpt_pkg::bpt_state_t state_reg, state_next;
    bpt_pkg::bpt_req_t   item_reg, item_next;
    bpt_pkg::bpt_rsp_t   res_reg, res_next;
    bpt_pkg::bpt_rsp_t   out_reg, out_next;
    logic                out_valid_reg, out_valid_next;

    logic [bpt_pkg::CNT_W-1:0]     scan_idx_reg, scan_idx_next;
    logic                          pipe_vld_reg, pipe_vld_next;
    logic [bpt_pkg::IDX_W-1:0]     pipe_idx_reg, pipe_idx_next;
    logic                          free_found_reg, free_found_next;
    logic [bpt_pkg::IDX_W-1:0]     free_idx_reg, free_idx_next;
    logic [bpt_pkg::IDX_W-1:0]     cur_idx_reg, cur_idx_next;
    logic [bpt_pkg::RES_CNT_W-1:0] n_cnt_reg, n_cnt_next;
    logic                          any_reg, any_next;
    logic [bpt_pkg::TABLE_SLOTS-1:0] valid_reg, valid_next;

    logic [31:0]       timeout_reg;
    logic signed [7:0] near_reg;
    logic signed [7:0] mid_reg;

    logic                      ram_we;
    logic [bpt_pkg::IDX_W-1:0] ram_waddr;
    logic [ENTRY_W-1:0]        ram_wdata;
    logic [bpt_pkg::IDX_W-1:0] ram_raddr;
    logic [ENTRY_W-1:0]        ram_rdata;
    bpt_pkg::bpt_entry_t       rd_entry;
    bpt_pkg::bpt_entry_t       wr_entry;

    logic any_valid;
    logic more_after;
    logic present;
    logic last;

    bpt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (bpt_pkg::TABLE_SLOTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_entry  = bpt_pkg::bpt_entry_t'(ram_rdata);
    assign ram_wdata = ENTRY_W'(wr_entry);

    assign req_stall = (state_reg != bpt_pkg::S_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;
    assign cfg_ready = 1'b1;

    assign any_valid = |valid_reg;

    // used slots above the one being reported
    always_comb
    begin
        more_after = 1'b0;
        for (int j = 0; j < bpt_pkg::TABLE_SLOTS; j++)
        begin
            if (valid_reg[j] && (bpt_pkg::IDX_W'(j) > cur_idx_reg))
            begin
                more_after = 1'b1;
            end
        end
    end

    assign present = (res_reg.age_ms <= timeout_reg);
    assign last    = !more_after || (n_cnt_reg == bpt_pkg::RES_CNT_W'(bpt_pkg::MAX_RESULTS - 1));

    always_comb
    begin
        state_next      = state_reg;
        item_next       = item_reg;
        res_next        = res_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        scan_idx_next   = scan_idx_reg;
        pipe_vld_next   = pipe_vld_reg;
        pipe_idx_next   = pipe_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        cur_idx_next    = cur_idx_reg;
        n_cnt_next      = n_cnt_reg;
        any_next        = any_reg;
        valid_next      = valid_reg;
        ram_we          = 1'b0;
        ram_waddr       = cur_idx_reg;
        ram_raddr       = scan_idx_reg[bpt_pkg::IDX_W-1:0];
        wr_entry.sender       = item_reg.sender_id;
        wr_entry.sequence_num = item_reg.sequence_req;
        wr_entry.seen_time    = item_reg.timestamp_ms;
        wr_entry.strength     = item_reg.signal_strength;

        // output beat taken
        if (out_valid_reg && !rsp_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            bpt_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    item_next = req;
                    res_next = '0;
                    res_next.last_of_run = 1'b1;
                    scan_idx_next = '0;
                    pipe_vld_next = 1'b0;
                    free_found_next = 1'b0;
                    n_cnt_next = '0;
                    any_next = 1'b0;
                    if (req.command == bpt_pkg::CMD_BEACON)
                    begin
                        res_next.kind = bpt_pkg::KIND_BEACON;
                        if (req.payload_length != bpt_pkg::GOOD_LENGTH)
                        begin
                            res_next.beacon_status = bpt_pkg::ST_BAD_LEN;
                            state_next = bpt_pkg::S_EMIT;
                        end
                        else
                        begin
                            state_next = bpt_pkg::S_LOOKUP;
                        end
                    end
                    else if (!any_valid)
                    begin
                        res_next.kind = bpt_pkg::KIND_EMPTY;
                        state_next = bpt_pkg::S_EMIT;
                    end
                    else
                    begin
                        state_next = bpt_pkg::S_RFIND;
                    end
                end
            end

            bpt_pkg::S_LOOKUP:
            begin
                // issue one read a cycle, compare the previous read
                if (scan_idx_reg < bpt_pkg::CNT_W'(bpt_pkg::TABLE_SLOTS))
                begin
                    pipe_vld_next = 1'b1;
                    pipe_idx_next = scan_idx_reg[bpt_pkg::IDX_W-1:0];
                    scan_idx_next = scan_idx_reg + 1'b1;
                    if (!valid_reg[scan_idx_reg[bpt_pkg::IDX_W-1:0]] && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next = scan_idx_reg[bpt_pkg::IDX_W-1:0];
                    end
                end
                else
                begin
                    pipe_vld_next = 1'b0;
                end

                if (pipe_vld_reg && valid_reg[pipe_idx_reg]
                    && (rd_entry.sender == item_reg.sender_id))
                begin
                    cur_idx_next = pipe_idx_reg;
                    res_next.beacon_status = bpt_pkg::ST_UPDATED;
                    res_next.slot_index = bpt_pkg::SLOT_W'(pipe_idx_reg);
                    state_next = bpt_pkg::S_WRITE;
                end
                else if (!pipe_vld_reg
                         && (scan_idx_reg >= bpt_pkg::CNT_W'(bpt_pkg::TABLE_SLOTS)))
                begin
                    if (free_found_reg)
                    begin
                        cur_idx_next = free_idx_reg;
                        res_next.beacon_status = bpt_pkg::ST_NEW;
                        res_next.slot_index = bpt_pkg::SLOT_W'(free_idx_reg);
                        state_next = bpt_pkg::S_WRITE;
                    end
                    else
                    begin
                        res_next.beacon_status = bpt_pkg::ST_FULL;
                        state_next = bpt_pkg::S_EMIT;
                    end
                end
            end

            bpt_pkg::S_WRITE:
            begin
                ram_we = 1'b1;
                valid_next[cur_idx_reg] = 1'b1;
                state_next = bpt_pkg::S_EMIT;
            end

            bpt_pkg::S_RFIND:
            begin
                scan_idx_next = scan_idx_reg + 1'b1;
                if (valid_reg[scan_idx_reg[bpt_pkg::IDX_W-1:0]])
                begin
                    cur_idx_next = scan_idx_reg[bpt_pkg::IDX_W-1:0];
                    state_next = bpt_pkg::S_RDATA;
                end
            end

            bpt_pkg::S_RDATA:
            begin
                res_next = '0;
                res_next.kind = bpt_pkg::KIND_ENTRY;
                res_next.slot_index = bpt_pkg::SLOT_W'(cur_idx_reg);
                res_next.entry_id = rd_entry.sender;
                res_next.age_ms = item_reg.timestamp_ms - rd_entry.seen_time;
                res_next.last_sequence = rd_entry.sequence_num;
                res_next.last_strength = rd_entry.strength;
                state_next = bpt_pkg::S_RCALC;
            end

            bpt_pkg::S_RCALC:
            begin
                res_next.is_present = present;
                res_next.distance_class =
                    bpt_pkg::classify(res_reg.last_strength, near_reg, mid_reg);
                any_next = any_reg | present;
                res_next.last_of_run = last;
                res_next.any_present = last && (any_reg | present);
                n_cnt_next = n_cnt_reg + 1'b1;
                state_next = bpt_pkg::S_EMIT;
            end

            bpt_pkg::S_EMIT:
            begin
                if (!out_valid_reg || !rsp_stall)
                begin
                    out_valid_next = 1'b1;
                    out_next = res_reg;
                    if (res_reg.last_of_run)
                    begin
                        state_next = bpt_pkg::S_IDLE;
                    end
                    else
                    begin
                        state_next = bpt_pkg::S_RFIND;
                    end
                end
            end

            default:
            begin
                state_next = bpt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= bpt_pkg::S_IDLE;
            out_valid_reg  <= 1'b0;
            scan_idx_reg   <= '0;
            pipe_vld_reg   <= 1'b0;
            free_found_reg <= 1'b0;
            n_cnt_reg      <= '0;
            any_reg        <= 1'b0;
            valid_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            scan_idx_reg   <= scan_idx_next;
            pipe_vld_reg   <= pipe_vld_next;
            free_found_reg <= free_found_next;
            n_cnt_reg      <= n_cnt_next;
            any_reg        <= any_next;
            valid_reg      <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        res_reg      <= res_next;
        out_reg      <= out_next;
        pipe_idx_reg <= pipe_idx_next;
        free_idx_reg <= free_idx_next;
        cur_idx_reg  <= cur_idx_next;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= bpt_pkg::TIMEOUT_RESET;
            near_reg    <= bpt_pkg::NEAR_RESET;
            mid_reg     <= bpt_pkg::MID_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                bpt_pkg::CFG_TIMEOUT:
                begin
                    timeout_reg <= cfg_data[31:0];
                end
                bpt_pkg::CFG_NEAR:
                begin
                    near_reg <= cfg_data[7:0];
                end
                bpt_pkg::CFG_MID:
                begin
                    mid_reg <= cfg_data[7:0];
                end
                default:
                begin
                    timeout_reg <= timeout_reg;
                end
            endcase
        end
    end

endmodule

@@ rtl/bpt_ram.sv @@
// bpt_ram: generic single-write, single-read ram with registered read data
// no dependencies
module bpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ sim/beacon_presence_table_unit_tb.sv @@
`timescale 1ns / 1ps
// self-checking bench for beacon_presence_table_unit: directed rows, then random beacons
// and reports over several register settings and idle patterns; depends on bpt_pkg
module beacon_presence_table_unit_tb;

    localparam int POOL_N = 36;
    localparam int RAND_PER_PHASE = 27;
    localparam logic [bpt_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct {
        bpt_pkg::bpt_req_t item;
        bit                typed;
        bpt_pkg::bpt_rsp_t answer;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    bpt_pkg::bpt_req_t req;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    bpt_pkg::bpt_rsp_t rsp;
    logic cfg_valid;
    logic cfg_ready;
    logic [bpt_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [bpt_pkg::CFG_DATA_W-1:0] cfg_data;

    // tracked table contents and register copies
    bit                seen_used [bpt_pkg::TABLE_SLOTS];
    logic [31:0]       seen_id   [bpt_pkg::TABLE_SLOTS];
    logic [31:0]       seen_seq  [bpt_pkg::TABLE_SLOTS];
    logic [31:0]       seen_at   [bpt_pkg::TABLE_SLOTS];
    logic signed [7:0] seen_rssi [bpt_pkg::TABLE_SLOTS];
    logic [31:0]       timeout_cfg;
    logic signed [7:0] near_cfg;
    logic signed [7:0] mid_cfg;

    bpt_pkg::bpt_rsp_t item_answers[$];
    bpt_pkg::bpt_rsp_t presence_answers[$];
    bpt_pkg::bpt_rsp_t oldest_beat;
    dir_row_t          dir_rows[$];
    logic [31:0]       id_pool[POOL_N];
    logic [31:0]       clock_ms;
    int unsigned       sender_pct;
    int unsigned       stall_pct;
    int                fail_count;

    beacon_presence_table_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        rsp_stall <= ($urandom_range(99) < stall_pct);
    end

    function automatic bpt_pkg::bpt_req_t make_req(logic cmd, logic [31:0] id, logic [31:0] seq,
                                                   int rssi, int len, logic [31:0] ts);
        bpt_pkg::bpt_req_t r;
        r.command         = cmd;
        r.sender_id       = id;
        r.sequence_req    = seq;
        r.signal_strength = rssi[7:0];
        r.payload_length  = len[7:0];
        r.timestamp_ms    = ts;
        return r;
    endfunction

    function automatic bpt_pkg::bpt_rsp_t single_beat(logic [1:0] kind, logic [1:0] st,
                                                      int slot);
        bpt_pkg::bpt_rsp_t b;
        b               = '0;
        b.kind          = kind;
        b.beacon_status = st;
        b.slot_index    = slot[bpt_pkg::SLOT_W-1:0];
        b.last_of_run   = 1'b1;
        return b;
    endfunction

    function automatic void add_row(bpt_pkg::bpt_req_t r, bit typed, bpt_pkg::bpt_rsp_t ans);
        dir_row_t row;
        row.item   = r;
        row.typed  = typed;
        row.answer = ans;
        dir_rows.push_back(row);
    endfunction

    // beats one item produces, given the tracked table
    function automatic void track_presence(bpt_pkg::bpt_req_t r);
        int                hit;
        int                i;
        bit                any;
        logic [31:0]       age;
        bpt_pkg::bpt_rsp_t b;
        item_answers.delete();
        if (r.command == bpt_pkg::CMD_BEACON)
        begin
            b = single_beat(bpt_pkg::KIND_BEACON, bpt_pkg::ST_BAD_LEN, 0);
            if (r.payload_length == bpt_pkg::GOOD_LENGTH)
            begin
                hit = -1;
                for (i = 0; i < bpt_pkg::TABLE_SLOTS; i++)
                begin
                    if (hit < 0 && seen_used[i] && seen_id[i] == r.sender_id)
                        hit = i;
                end
                b.beacon_status = bpt_pkg::ST_UPDATED;
                if (hit < 0)
                begin
                    for (i = 0; i < bpt_pkg::TABLE_SLOTS; i++)
                    begin
                        if (hit < 0 && !seen_used[i])
                            hit = i;
                    end
                    b.beacon_status = bpt_pkg::ST_NEW;
                    if (hit >= 0)
                    begin
                        seen_used[hit] = 1'b1;
                        seen_id[hit]   = r.sender_id;
                    end
                end
                if (hit < 0)
                begin
                    b.beacon_status = bpt_pkg::ST_FULL;
                end
                else
                begin
                    seen_seq[hit]  = r.sequence_req;
                    seen_at[hit]   = r.timestamp_ms;
                    seen_rssi[hit] = r.signal_strength;
                    b.slot_index   = 5'(hit);
                end
            end
            item_answers.push_back(b);
        end
        else
        begin
            any = 1'b0;
            for (i = 0; i < bpt_pkg::TABLE_SLOTS; i++)
            begin
                if (seen_used[i])
                begin
                    age             = r.timestamp_ms - seen_at[i];
                    b               = '0;
                    b.kind          = bpt_pkg::KIND_ENTRY;
                    b.slot_index    = 5'(i);
                    b.entry_id      = seen_id[i];
                    b.is_present    = (age <= timeout_cfg);
                    b.age_ms        = age;
                    b.last_sequence = seen_seq[i];
                    b.last_strength = seen_rssi[i];
                    if (seen_rssi[i] >= near_cfg)
                        b.distance_class = bpt_pkg::CLASS_NEAR;
                    else if (seen_rssi[i] >= mid_cfg)
                        b.distance_class = bpt_pkg::CLASS_MID;
                    else
                        b.distance_class = bpt_pkg::CLASS_FAR;
                    if (b.is_present)
                        any = 1'b1;
                    item_answers.push_back(b);
                end
            end
            if (item_answers.size() == 0)
            begin
                item_answers.push_back(single_beat(bpt_pkg::KIND_EMPTY, bpt_pkg::ST_UPDATED, 0));
            end
            else
            begin
                b             = item_answers[item_answers.size() - 1];
                b.any_present = any;
                b.last_of_run = 1'b1;
                item_answers[item_answers.size() - 1] = b;
            end
        end
    endfunction

    function automatic bpt_pkg::bpt_req_t rand_item();
        bpt_pkg::bpt_req_t r;
        clock_ms = clock_ms + $urandom_range(0, 1200);
        if ($urandom_range(99) < 5)
            clock_ms = $urandom;
        r.command         = bpt_pkg::CMD_BEACON;
        r.sender_id       = $urandom;
        r.sequence_req    = $urandom;
        r.signal_strength = 8'($urandom_range(0, 255));
        r.payload_length  = bpt_pkg::GOOD_LENGTH;
        r.timestamp_ms    = clock_ms;
        if ($urandom_range(99) < 25)
        begin
            r.command        = bpt_pkg::CMD_REPORT;
            r.payload_length = 8'($urandom_range(0, 255));
        end
        else
        begin
            if ($urandom_range(99) < 85)
                r.sender_id = id_pool[$urandom_range(0, POOL_N - 1)];
            if ($urandom_range(99) < 10)
                r.payload_length = 8'($urandom_range(0, 255));
        end
        return r;
    endfunction

    function automatic void cmp_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (presence_answers.size() == 0)
            begin
                $display("%0t: unexpected beat, expected none actual %h", $time, rsp);
                fail_count++;
            end
            else
            begin
                oldest_beat = presence_answers.pop_front();
                cmp_field("kind", 32'(oldest_beat.kind), 32'(rsp.kind));
                cmp_field("beacon_status", 32'(oldest_beat.beacon_status),
                          32'(rsp.beacon_status));
                cmp_field("slot_index", 32'(oldest_beat.slot_index), 32'(rsp.slot_index));
                cmp_field("entry_id", oldest_beat.entry_id, rsp.entry_id);
                cmp_field("is_present", 32'(oldest_beat.is_present), 32'(rsp.is_present));
                cmp_field("age_ms", oldest_beat.age_ms, rsp.age_ms);
                cmp_field("last_sequence", oldest_beat.last_sequence, rsp.last_sequence);
                cmp_field("last_strength", 32'(oldest_beat.last_strength),
                          32'(rsp.last_strength));
                cmp_field("distance_class", 32'(oldest_beat.distance_class),
                          32'(rsp.distance_class));
                cmp_field("any_present", 32'(oldest_beat.any_present),
                          32'(rsp.any_present));
                cmp_field("last_of_run", 32'(oldest_beat.last_of_run),
                          32'(rsp.last_of_run));
            end
        end
    end

    // called at a falling edge, returns at the falling edge after the item is taken
    task automatic send_item(bpt_pkg::bpt_req_t r, bit typed, bpt_pkg::bpt_rsp_t ans);
        int j;
        while ($urandom_range(99) < sender_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req       <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        track_presence(r);
        if (typed)
        begin
            presence_answers.push_back(ans);
        end
        else
        begin
            for (j = 0; j < item_answers.size(); j++)
                presence_answers.push_back(item_answers[j]);
        end
        @(negedge clk);
    endtask

    task automatic write_reg(logic [bpt_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == bpt_pkg::CFG_TIMEOUT)
            timeout_cfg = val;
        else if (idx == bpt_pkg::CFG_NEAR)
            near_cfg = val[7:0];
        else if (idx == bpt_pkg::CFG_MID)
            mid_cfg = val[7:0];
        @(negedge clk);
    endtask

    task automatic program_regs(logic [31:0] tmo, int near_lvl, int mid_lvl);
        logic [31:0] junk;
        junk = $urandom;
        write_reg(bpt_pkg::CFG_TIMEOUT, tmo);
        write_reg(bpt_pkg::CFG_NEAR, {junk[31:8], near_lvl[7:0]});
        junk = $urandom;
        write_reg(bpt_pkg::CFG_MID, {junk[31:8], mid_lvl[7:0]});
        // unmapped index, must leave all registers alone
        write_reg(CFG_UNUSED, $urandom);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (presence_answers.size() != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    initial
    begin
        int k;
        int phase;
        int n;
        rst_n      = 1'b0;
        req_valid  = 1'b0;
        req        = '0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        sender_pct = 0;
        stall_pct  = 0;
        fail_count = 0;
        clock_ms   = 32'hFFFF_F000;
        for (k = 0; k < bpt_pkg::TABLE_SLOTS; k++)
            seen_used[k] = 1'b0;
        timeout_cfg = bpt_pkg::TIMEOUT_RESET;
        near_cfg    = bpt_pkg::NEAR_RESET;
        mid_cfg     = bpt_pkg::MID_RESET;
        for (k = 0; k < POOL_N; k++)
            id_pool[k] = $urandom;

        add_row(make_req(bpt_pkg::CMD_REPORT, 0, 0, 0, 0, 100), 1,
                single_beat(bpt_pkg::KIND_EMPTY, bpt_pkg::ST_UPDATED, 0));
        add_row(make_req(bpt_pkg::CMD_BEACON, 32'h1111_1111, 5, -50, 0, 110), 1,
                single_beat(bpt_pkg::KIND_BEACON, bpt_pkg::ST_BAD_LEN, 0));
        add_row(make_req(bpt_pkg::CMD_BEACON, 32'h1111_1111, 5, -50, 255, 120), 1,
                single_beat(bpt_pkg::KIND_BEACON, bpt_pkg::ST_BAD_LEN, 0));
        add_row(make_req(bpt_pkg::CMD_BEACON, 32'h1111_1111, 5, -50, 11, 130), 1,
                single_beat(bpt_pkg::KIND_BEACON, bpt_pkg::ST_BAD_LEN, 0));
        add_row(make_req(bpt_pkg::CMD_BEACON, 32'h1111_1111, 5, -50, 13, 140), 1,
                single_beat(bpt_pkg::KIND_BEACON, bpt_pkg::ST_BAD_LEN, 0));
        add_row(make_req(bpt_pkg::CMD_REPORT, 0, 0, 0, 0, 200), 1,
                single_beat(bpt_pkg::KIND_EMPTY, bpt_pkg::ST_UPDATED, 0));
        add_row(make_req(bpt_pkg::CMD_BEACON, 0, 0, -128, 12, 1000), 1,
                single_beat(bpt_pkg::KIND_BEACON, bpt_pkg::ST_NEW, 0));
        add_row(make_req(bpt_pkg::CMD_BEACON, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 127, 12, 1000), 1,
                single_beat(bpt_pkg::KIND_BEACON, bpt_pkg::ST_NEW, 1));
        add_row(make_req(bpt_pkg::CMD_BEACON, 32'h1234_5678, 1, -70, 12, 2000), 1,
                single_beat(bpt_pkg::KIND_BEACON, bpt_pkg::ST_NEW, 2));
        add_row(make_req(bpt_pkg::CMD_BEACON, 32'h9ABC_DEF0, 2, -71, 12, 2000), 1,
                single_beat(bpt_pkg::KIND_BEACON, bpt_pkg::ST_NEW, 3));
        add_row(make_req(bpt_pkg::CMD_BEACON, 32'hA5A5_A5A5, 3, -85, 12, 2000), 1,
                single_beat(bpt_pkg::KIND_BEACON, bpt_pkg::ST_NEW, 4));
        add_row(make_req(bpt_pkg::CMD_BEACON, 32'h5A5A_5A5A, 4, -86, 12, 2000), 1,
                single_beat(bpt_pkg::KIND_BEACON, bpt_pkg::ST_NEW, 5));
        add_row(make_req(bpt_pkg::CMD_BEACON, 32'h1234_5678, 7, -60, 12, 3000), 1,
                single_beat(bpt_pkg::KIND_BEACON, bpt_pkg::ST_UPDATED, 2));
        add_row(make_req(bpt_pkg::CMD_BEACON, 0, 9, -20, 200, 3000), 1,
                single_beat(bpt_pkg::KIND_BEACON, bpt_pkg::ST_BAD_LEN, 0));
        add_row(make_req(bpt_pkg::CMD_REPORT, 0, 0, 0, 0, 3000), 0, '0);
        add_row(make_req(bpt_pkg::CMD_REPORT, 0, 0, 0, 0, 3500), 0, '0);
        add_row(make_req(bpt_pkg::CMD_REPORT, 0, 0, 0, 0, 3501), 0, '0);
        add_row(make_req(bpt_pkg::CMD_REPORT, 0, 0, 0, 0, 32'hFFFF_0000), 0, '0);
        add_row(make_req(bpt_pkg::CMD_BEACON, 0, 11, -100, 12, 32'hFFFF_FFF0), 1,
                single_beat(bpt_pkg::KIND_BEACON, bpt_pkg::ST_UPDATED, 0));
        add_row(make_req(bpt_pkg::CMD_REPORT, 0, 0, 0, 0, 32'h10), 0, '0);
        add_row(make_req(bpt_pkg::CMD_REPORT, 32'hDEAD_BEEF, 32'hFFFF_FFFF, -1, 12, 32'h20),
                0, '0);

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[k])
            send_item(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].answer);

        for (phase = 0; phase < 4; phase++)
        begin
            drain();
            case (phase)
                0:
                begin
                    program_regs(bpt_pkg::TIMEOUT_RESET, -70, -85);
                    sender_pct = 0;
                    stall_pct  = 0;
                end
                1:
                begin
                    program_regs(32'd0, 127, -128);
                    sender_pct = 66;
                    stall_pct  = 0;
                end
                2:
                begin
                    program_regs(32'hFFFF_FFFF, -128, 127);
                    sender_pct = 0;
                    stall_pct  = 66;
                end
                default:
                begin
                    program_regs($urandom_range(0, 4000), $urandom_range(0, 255) - 128,
                                 $urandom_range(0, 255) - 128);
                    sender_pct = 31;
                    stall_pct  = 31;
                end
            endcase
            for (n = 0; n < RAND_PER_PHASE; n++)
                send_item(rand_item(), 0, '0);
        end

        drain();
        repeat (150) @(negedge clk);
        if (fail_count == 0 && presence_answers.size() == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial
    begin
        #1_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/bpt_pkg.sv
rtl/bpt_ram.sv
rtl/beacon_presence_table_unit.sv
sim/beacon_presence_table_unit_tb.sv
